/* src/tgc_pkg.sv */
// ----------------------------------------------------------------------------
// tgc_pkg
// Types, constants and register indexes shared by the touch gesture
// classifier modules.
// ----------------------------------------------------------------------------
package tgc_pkg;

  // Reset values of the configuration registers.
  localparam logic [15:0] ScreenWidthRst  = 16'd240;
  localparam logic [15:0] HoldTimeRst     = 16'd1000;
  localparam logic [15:0] SwipeXThrRst    = 16'd80;
  localparam logic [15:0] SwipeYThrRst    = 16'd60;

  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SCREEN_WIDTH  = 2'd0,
    CFG_HOLD_TIME     = 2'd1,
    CFG_SWIPE_X_THR   = 2'd2,
    CFG_SWIPE_Y_THR   = 2'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    EV_NONE    = 4'd0,
    EV_CLICK   = 4'd1,
    EV_HOLD    = 4'd2,
    EV_RIGHT   = 4'd3,
    EV_LEFT    = 4'd4,
    EV_DOWN    = 4'd5,
    EV_UP      = 4'd6,
    EV_LONG    = 4'd7,
    EV_RELEASE = 4'd8,
    EV_TWO     = 4'd9
  } event_e;

  typedef struct packed {
    logic [1:0]  finger_count;
    logic [15:0] first_raw_x;
    logic [15:0] first_raw_y;
    logic [15:0] second_raw_x;
    logic [15:0] second_raw_y;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  event_code;
    logic [15:0] start_x;
    logic [15:0] start_y;
    logic [15:0] end_x;
    logic [15:0] end_y;
  } out_item_t;

  typedef struct packed {
    logic [15:0] screen_width;
    logic [15:0] hold_time_ms;
    logic [15:0] swipe_x_threshold;
    logic [15:0] swipe_y_threshold;
  } cfg_t;

  // Gesture tracking state carried from one poll to the next.
  typedef struct packed {
    logic [1:0]  prev_count;
    event_e      last_event;
    logic        hold_sent;
    logic [31:0] press_time;
    logic [15:0] point_a_x;
    logic [15:0] point_a_y;
    logic [15:0] point_b_x;
    logic [15:0] point_b_y;
  } gst_t;

  // Verdict of the classify stage for one poll.
  typedef struct packed {
    logic      emit;
    out_item_t item;
  } verdict_t;

endpackage

/* src/tgc_cfg.sv */
// ----------------------------------------------------------------------------
// tgc_cfg
// Configuration register file of the touch gesture classifier.
// ----------------------------------------------------------------------------
module tgc_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [tgc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0]                 cfg_data_i,
  output tgc_pkg::cfg_t               cfg_o
);

  tgc_pkg::cfg_t cfg_q, cfg_d;

  // Writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (tgc_pkg::cfg_reg_e'(cfg_index_i))
        tgc_pkg::CFG_SCREEN_WIDTH:  cfg_d.screen_width      = cfg_data_i;
        tgc_pkg::CFG_HOLD_TIME:     cfg_d.hold_time_ms      = cfg_data_i;
        tgc_pkg::CFG_SWIPE_X_THR:   cfg_d.swipe_x_threshold = cfg_data_i;
        tgc_pkg::CFG_SWIPE_Y_THR:   cfg_d.swipe_y_threshold = cfg_data_i;
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_width      <= tgc_pkg::ScreenWidthRst;
      cfg_q.hold_time_ms      <= tgc_pkg::HoldTimeRst;
      cfg_q.swipe_x_threshold <= tgc_pkg::SwipeXThrRst;
      cfg_q.swipe_y_threshold <= tgc_pkg::SwipeYThrRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* src/tgc_classify.sv */
// ----------------------------------------------------------------------------
// tgc_classify
// Combinational gesture decision for one registered poll: next tracking
// state and the result item, if any.
// ----------------------------------------------------------------------------
module tgc_classify (
  input  tgc_pkg::in_item_t item_i,
  input  tgc_pkg::gst_t     state_i,
  input  tgc_pkg::cfg_t     cfg_i,
  output tgc_pkg::gst_t     state_o,
  output tgc_pkg::verdict_t verdict_o
);

  logic [31:0]        elapsed;
  logic               long_press;
  logic [15:0]        rot_a_x, rot_b_x;
  logic signed [17:0] dx, ndx, dy, ndy, thr_x, thr_y;
  logic               has_code;
  tgc_pkg::event_e    code;
  tgc_pkg::gst_t      nxt;

  assign elapsed    = item_i.now_ms - state_i.press_time;
  assign long_press = elapsed > {16'd0, cfg_i.hold_time_ms};

  // Rotation into display space: x' = width - y, y' = x, modulo 2^16.
  assign rot_a_x = cfg_i.screen_width - item_i.first_raw_y;
  assign rot_b_x = cfg_i.screen_width - item_i.second_raw_y;

  // Travel on release: the new end point is the first raw point.
  assign dx  = $signed({2'b00, rot_a_x}) - $signed({2'b00, state_i.point_a_x});
  assign ndx = $signed({2'b00, state_i.point_a_x}) - $signed({2'b00, rot_a_x});
  assign dy  = $signed({2'b00, item_i.first_raw_x})
             - $signed({2'b00, state_i.point_a_y});
  assign ndy = $signed({2'b00, state_i.point_a_y})
             - $signed({2'b00, item_i.first_raw_x});
  assign thr_x = $signed({2'b00, cfg_i.swipe_x_threshold});
  assign thr_y = $signed({2'b00, cfg_i.swipe_y_threshold});

  always_comb begin
    nxt      = state_i;
    has_code = 1'b0;
    code     = tgc_pkg::EV_NONE;
    if (item_i.finger_count == state_i.prev_count) begin
      if (state_i.prev_count != 2'd0 && !state_i.hold_sent && long_press) begin
        nxt.hold_sent = 1'b1;
        has_code      = 1'b1;
        code          = tgc_pkg::EV_HOLD;
      end
    end else begin
      nxt.prev_count = item_i.finger_count;
      if (state_i.prev_count == 2'd0 && item_i.finger_count == 2'd1) begin
        nxt.point_a_x  = rot_a_x;
        nxt.point_a_y  = item_i.first_raw_x;
        nxt.hold_sent  = 1'b0;
        nxt.press_time = item_i.now_ms;
        has_code       = 1'b1;
        code           = tgc_pkg::EV_CLICK;
      end else if (state_i.prev_count == 2'd1 && item_i.finger_count == 2'd0) begin
        nxt.point_b_x = rot_a_x;
        nxt.point_b_y = item_i.first_raw_x;
        has_code      = 1'b1;
        if (dx > thr_x) begin
          code = tgc_pkg::EV_RIGHT;
        end else if (ndx > thr_x) begin
          code = tgc_pkg::EV_LEFT;
        end else if (dy > thr_y) begin
          code = tgc_pkg::EV_DOWN;
        end else if (ndy > thr_y) begin
          code = tgc_pkg::EV_UP;
        end else if (long_press) begin
          code = tgc_pkg::EV_LONG;
        end else begin
          code = tgc_pkg::EV_RELEASE;
        end
      end else if (state_i.prev_count == 2'd0 && item_i.finger_count == 2'd2) begin
        nxt.point_a_x  = rot_a_x;
        nxt.point_a_y  = item_i.first_raw_x;
        nxt.point_b_x  = rot_b_x;
        nxt.point_b_y  = item_i.second_raw_x;
        nxt.press_time = item_i.now_ms;
        has_code       = 1'b1;
        code           = tgc_pkg::EV_TWO;
      end else if (state_i.prev_count == 2'd2 && item_i.finger_count == 2'd0) begin
        has_code = 1'b1;
        code     = tgc_pkg::EV_RELEASE;
      end
    end

    // A repeat of the last reported event is swallowed.
    verdict_o.emit = has_code && (code != state_i.last_event);
    if (verdict_o.emit) begin
      nxt.last_event = code;
    end
    verdict_o.item.event_code = code;
    verdict_o.item.start_x    = nxt.point_a_x;
    verdict_o.item.start_y    = nxt.point_a_y;
    verdict_o.item.end_x      = nxt.point_b_x;
    verdict_o.item.end_y      = nxt.point_b_y;
    state_o = nxt;
  end

endmodule

/* src/touch_gesture_classifier.sv */
// ----------------------------------------------------------------------------
// touch_gesture_classifier
// Turns touch-controller polls (finger count, two raw points, millisecond
// time) into gesture events: click, hold, two-finger click, release, long
// click and swipes right, left, down and up. Points are rotated into display
// space as x' = width - y and y' = x. An event is reported only when its code
// differs from the last one reported, so most polls produce no transaction.
// A poll is taken every cycle unless the input is stalled: it lands in an
// input register, is classified in the next cycle against the tracking
// state (a 32-bit elapsed-time subtract and compare beside four 18-bit
// travel compares), and any result goes to the output register as the poll
// advances; throughput is one poll per clock while no result waits on a
// stalled output. The output register lets the next poll be classified
// while a result waits; a poll that produces no event goes through even
// while the output side is stalled. Configuration writes are always taken
// and should be done while no poll is in flight.
// ----------------------------------------------------------------------------
module touch_gesture_classifier (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Poll input channel.
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  tgc_pkg::in_item_t           in_data_i,
  // Event output channel.
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output tgc_pkg::out_item_t          out_data_o,
  // Configuration write channel.
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [tgc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0]                 cfg_data_i
);

  tgc_pkg::cfg_t      cfg;
  tgc_pkg::in_item_t  in_q;
  logic               in_vld_q, in_vld_d;
  tgc_pkg::gst_t      state_q, state_d;
  tgc_pkg::verdict_t  verdict;
  tgc_pkg::out_item_t out_q;
  logic               out_vld_q, out_vld_d;
  logic               in_take, out_take, advance, out_load;

  tgc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  tgc_classify u_classify (
    .item_i    (in_q),
    .state_i   (state_q),
    .cfg_i     (cfg),
    .state_o   (state_d),
    .verdict_o (verdict)
  );

  // The registered poll moves on when it has no result to deliver, or when
  // the output register is empty or being emptied in this cycle.
  assign out_take = out_vld_q && !out_stall_i;
  assign advance  = in_vld_q && (!verdict.emit || !out_vld_q || !out_stall_i);
  assign out_load = advance && verdict.emit;

  // The input register can be refilled in the same cycle that it drains.
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (out_take) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  // Payload registers, loaded only on a handshake.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (out_load) begin
      out_q <= verdict.item;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // A reported event always becomes the new last event.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (state_q.last_event == tgc_pkg::event_e'(out_q.event_code)))
    else $error("last event does not track the reported event");

  // A result never repeats the previous event and is never the none code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (verdict.item.event_code != state_q.last_event &&
                  verdict.item.event_code != tgc_pkg::EV_NONE))
    else $error("repeated or empty event reported");

  // Stall is only raised with a poll held in the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_vld_q)
    else $error("stall raised with an empty input register");

  // A held poll is not dropped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !advance) |=> (in_vld_q && $stable(in_q)))
    else $error("held poll lost");

  // A waiting result is never overwritten before it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_stall_i) |-> !out_load)
    else $error("stalled result overwritten");

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// Touch gesture classifier testbench
// Sends touch polls through the classifier and checks every gesture event
// against a cycle-free software copy of the classifier kept in this bench.
// A directed sequence comes first. Random gesture sequences follow under
// several register settings and several patterns of sender gaps and
// receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit  = 500000;
  localparam int DrainCycles = 8;      // lets the pipeline empty, with margin
  localparam int PhaseItems  = 230;
  localparam int NumPhases   = 8;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  tgc_pkg::in_item_t  in_data_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  tgc_pkg::out_item_t out_data_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [tgc_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [15:0]        cfg_data_i = '0;

  touch_gesture_classifier dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Polls waiting to be sent and gesture events still owed by the block.
  tgc_pkg::in_item_t  pending_polls[$];
  tgc_pkg::out_item_t expected_events[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int error_count = 0;
  int polls_taken = 0;
  int events_seen = 0;
  int cycle_count = 0;
  int settings_used = 1;
  int phase_polls = 0;
  logic [31:0] poll_clock = '0;

  // Register copy, reset values from the package.
  tgc_pkg::cfg_t cfg_mirror = '{tgc_pkg::ScreenWidthRst, tgc_pkg::HoldTimeRst,
                                tgc_pkg::SwipeXThrRst, tgc_pkg::SwipeYThrRst};

  // Gesture tracking state of the classifier as the bench sees it.
  logic [1:0]      trk_count = '0;
  tgc_pkg::event_e trk_last = tgc_pkg::EV_NONE;
  logic            trk_hold_sent = 1'b0;
  logic [31:0]     trk_press_time = '0;
  logic [15:0]     trk_ax = '0, trk_ay = '0, trk_bx = '0, trk_by = '0;

  // Advances the tracking state by one accepted poll and queues the event
  // it produces, if the event code differs from the last one reported.
  function automatic void classify_poll(tgc_pkg::in_item_t p);
    logic [31:0]        elapsed;
    int                 dx, dy, ax_i, ay_i, bx_i, by_i, thr_x, thr_y;
    tgc_pkg::event_e    code;
    logic               fire;
    tgc_pkg::out_item_t ev;
    elapsed = p.now_ms - trk_press_time;
    fire = 1'b0;
    code = tgc_pkg::EV_NONE;
    if (p.finger_count == trk_count) begin
      // A hold fires at most once per press while the count stays put and nonzero.
      if (trk_count != 2'd0 && !trk_hold_sent && elapsed > cfg_mirror.hold_time_ms) begin
        trk_hold_sent = 1'b1;
        code = tgc_pkg::EV_HOLD;
        fire = 1'b1;
      end
    end else begin
      if (trk_count == 2'd0 && p.finger_count == 2'd1) begin
        trk_ax = cfg_mirror.screen_width - p.first_raw_y;
        trk_ay = p.first_raw_x;
        trk_hold_sent = 1'b0;
        trk_press_time = p.now_ms;
        code = tgc_pkg::EV_CLICK;
        fire = 1'b1;
      end else if (trk_count == 2'd1 && p.finger_count == 2'd0) begin
        trk_bx = cfg_mirror.screen_width - p.first_raw_y;
        trk_by = p.first_raw_x;
        ax_i = int'(trk_ax);
        ay_i = int'(trk_ay);
        bx_i = int'(trk_bx);
        by_i = int'(trk_by);
        thr_x = int'(cfg_mirror.swipe_x_threshold);
        thr_y = int'(cfg_mirror.swipe_y_threshold);
        dx = bx_i - ax_i;
        dy = by_i - ay_i;
        if (dx > thr_x) code = tgc_pkg::EV_RIGHT;
        else if (-dx > thr_x) code = tgc_pkg::EV_LEFT;
        else if (dy > thr_y) code = tgc_pkg::EV_DOWN;
        else if (-dy > thr_y) code = tgc_pkg::EV_UP;
        else if (elapsed > cfg_mirror.hold_time_ms) code = tgc_pkg::EV_LONG;
        else code = tgc_pkg::EV_RELEASE;
        fire = 1'b1;
      end else if (trk_count == 2'd0 && p.finger_count == 2'd2) begin
        // A two-finger press leaves the hold flag as it was.
        trk_ax = cfg_mirror.screen_width - p.first_raw_y;
        trk_ay = p.first_raw_x;
        trk_bx = cfg_mirror.screen_width - p.second_raw_y;
        trk_by = p.second_raw_x;
        trk_press_time = p.now_ms;
        code = tgc_pkg::EV_TWO;
        fire = 1'b1;
      end else if (trk_count == 2'd2 && p.finger_count == 2'd0) begin
        code = tgc_pkg::EV_RELEASE;
        fire = 1'b1;
      end
      trk_count = p.finger_count;
    end
    if (fire && code != trk_last) begin
      trk_last = code;
      ev.event_code = code;
      ev.start_x = trk_ax;
      ev.start_y = trk_ay;
      ev.end_x = trk_bx;
      ev.end_y = trk_by;
      expected_events.push_back(ev);
    end
  endfunction

  // Poll driver: holds a stalled transaction, otherwise offers the next
  // queued poll unless the random gap says to stay idle this cycle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        classify_poll(in_data_i);
        polls_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_polls.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i <= pending_polls.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endfunction

  // Event monitor: every accepted transaction is matched against the
  // oldest owed event, field by field.
  always @(posedge clk_i) begin
    tgc_pkg::out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        events_seen++;
        if (expected_events.size() == 0) begin
          $error("event %0d arrived with none expected", out_data_o.event_code);
          error_count++;
        end else begin
          want = expected_events.pop_front();
          check_field("event_code", {12'd0, want.event_code},
                      {12'd0, out_data_o.event_code});
          check_field("start_x", want.start_x, out_data_o.start_x);
          check_field("start_y", want.start_y, out_data_o.start_y);
          check_field("end_x", want.end_x, out_data_o.end_x);
          check_field("end_y", want.end_y, out_data_o.end_y);
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Timed out after %0d cycles with %0d events owed.",
               cycle_count, expected_events.size());
      $display("FAILURE");
      $finish;
    end
  end

  task automatic add_poll(logic [1:0] cnt, logic [15:0] ax, logic [15:0] ay,
                          logic [15:0] bx, logic [15:0] by, logic [31:0] now);
    tgc_pkg::in_item_t p;
    p.finger_count = cnt;
    p.first_raw_x = ax;
    p.first_raw_y = ay;
    p.second_raw_x = bx;
    p.second_raw_y = by;
    p.now_ms = now;
    pending_polls.push_back(p);
    phase_polls++;
  endtask

  // Time steps are scaled to the hold time so holds and long clicks land on
  // both sides of the limit; a few large jumps wrap the clock.
  function automatic logic [31:0] next_time();
    int unsigned r, h;
    r = $urandom_range(99);
    h = 32'(cfg_mirror.hold_time_ms);
    if (r < 60) poll_clock += $urandom_range(h / 2 + 1, 0);
    else if (r < 93) poll_clock += $urandom_range(2 * h + 2, h / 2);
    else poll_clock += $urandom;
    return poll_clock;
  endfunction

  // Travel in display space: within the threshold, just past it, or wild.
  function automatic logic [15:0] pick_travel(logic [15:0] thr);
    int unsigned r, mag;
    r = $urandom_range(99);
    if (r < 40) mag = $urandom_range(thr, 0);
    else if (r < 85) mag = thr + $urandom_range(40, 0);
    else mag = $urandom;
    return $urandom_range(1) ? mag[15:0] : -mag[15:0];
  endfunction

  task automatic add_gesture();
    int unsigned kind;
    logic [15:0] ax, ay, dxw, dyw;
    kind = $urandom_range(99);
    if (kind < 60) begin
      ax = 16'($urandom);
      ay = 16'($urandom);
      add_poll(2'd1, ax, ay, 16'($urandom), 16'($urandom), next_time());
      repeat ($urandom_range(3)) add_poll(2'd1, 16'($urandom), 16'($urandom),
                                          16'($urandom), 16'($urandom), next_time());
      if ($urandom_range(9) == 0) begin
        add_poll(2'd2, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 next_time());
        add_poll(2'd1, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 next_time());
      end
      // Rotation maps raw y to display x (negated) and raw x to display y.
      dxw = pick_travel(cfg_mirror.swipe_x_threshold);
      dyw = pick_travel(cfg_mirror.swipe_y_threshold);
      add_poll(2'd0, ax + dyw, ay - dxw, 16'($urandom), 16'($urandom), next_time());
    end else if (kind < 85) begin
      add_poll(2'd2, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
               next_time());
      repeat ($urandom_range(3)) add_poll(2'd2, 16'($urandom), 16'($urandom),
                                          16'($urandom), 16'($urandom), next_time());
      add_poll(($urandom_range(4) == 0) ? 2'd1 : 2'd0, 16'($urandom), 16'($urandom),
               16'($urandom), 16'($urandom), next_time());
    end else begin
      add_poll(2'($urandom_range(3)), 16'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom), ($urandom_range(1) == 0) ? next_time() : $urandom);
    end
    repeat ($urandom_range(2)) add_poll(2'd0, 16'($urandom), 16'($urandom),
                                        16'($urandom), 16'($urandom), next_time());
  endtask

  // Returns on a falling edge once every poll is taken, every event has
  // arrived, and polls that produce nothing have left the pipeline.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_polls.size() != 0 || in_valid_i || expected_events.size() != 0);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(tgc_pkg::cfg_reg_e idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    case (idx)
      tgc_pkg::CFG_SCREEN_WIDTH: cfg_mirror.screen_width = val;
      tgc_pkg::CFG_HOLD_TIME:    cfg_mirror.hold_time_ms = val;
      tgc_pkg::CFG_SWIPE_X_THR:  cfg_mirror.swipe_x_threshold = val;
      tgc_pkg::CFG_SWIPE_Y_THR:  cfg_mirror.swipe_y_threshold = val;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  task automatic program_regs(logic [15:0] w, logic [15:0] h, logic [15:0] tx,
                              logic [15:0] ty);
    write_reg(tgc_pkg::CFG_SCREEN_WIDTH, w);
    write_reg(tgc_pkg::CFG_HOLD_TIME, h);
    write_reg(tgc_pkg::CFG_SWIPE_X_THR, tx);
    write_reg(tgc_pkg::CFG_SWIPE_Y_THR, ty);
    @(negedge clk_i);
    settings_used++;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed sequence under the reset settings (width 240, hold 1000,
    // thresholds 80 and 60): every event, the repeat filter, count three,
    // and a press that straddles the wrap of the millisecond clock.
    add_poll(2'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'd0);
    add_poll(2'd1, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 32'd10);
    add_poll(2'd1, 16'h1234, 16'h5678, 16'h0000, 16'h0000, 32'd500);
    add_poll(2'd1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'd1011);
    add_poll(2'd1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'd1012);
    add_poll(2'd0, 16'd100, 16'd0, 16'h0000, 16'h0000, 32'd1100);
    add_poll(2'd1, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 32'd2000);
    add_poll(2'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd2100);
    add_poll(2'd1, 16'd1000, 16'd1000, 16'h0000, 16'h0000, 32'd3000);
    add_poll(2'd0, 16'd1000, 16'd900, 16'h0000, 16'h0000, 32'd3100);
    add_poll(2'd1, 16'd1000, 16'd1000, 16'h0000, 16'h0000, 32'd4000);
    add_poll(2'd0, 16'd1000, 16'd1100, 16'h0000, 16'h0000, 32'd4100);
    add_poll(2'd1, 16'd1000, 16'd1000, 16'h0000, 16'h0000, 32'd5000);
    add_poll(2'd0, 16'd900, 16'd1000, 16'h0000, 16'h0000, 32'd5100);
    add_poll(2'd1, 16'd1000, 16'd1000, 16'h0000, 16'h0000, 32'd6000);
    add_poll(2'd0, 16'd1000, 16'd1000, 16'h0000, 16'h0000, 32'd7500);
    add_poll(2'd2, 16'd10, 16'd20, 16'd30, 16'd40, 32'd8000);
    add_poll(2'd2, 16'd0, 16'd0, 16'd0, 16'd0, 32'd9500);
    add_poll(2'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd9600);
    // Count three never produces an event; the hold flag is still set from
    // the two-finger hold, and the second release is filtered as a repeat.
    add_poll(2'd3, 16'd0, 16'd0, 16'd0, 16'd0, 32'd9700);
    add_poll(2'd3, 16'd0, 16'd0, 16'd0, 16'd0, 32'd20000);
    add_poll(2'd2, 16'd0, 16'd0, 16'd0, 16'd0, 32'd20100);
    add_poll(2'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd20200);
    add_poll(2'd1, 16'd50, 16'd70, 16'd0, 16'd0, 32'hFFFF_FF00);
    add_poll(2'd1, 16'd0, 16'd0, 16'd0, 16'd0, 32'h0000_0200);
    add_poll(2'd1, 16'd0, 16'd0, 16'd0, 16'd0, 32'h0000_0400);
    add_poll(2'd0, 16'd50, 16'd70, 16'd0, 16'd0, 32'h0000_0500);
    wait_drained();

    // Random phases: the first three settings are the defaults and the two
    // extremes, the rest are random. The idle pattern cycles through no
    // gaps, sender gaps, receiver stalls, and light gaps on both sides.
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: program_regs(tgc_pkg::ScreenWidthRst, tgc_pkg::HoldTimeRst,
                        tgc_pkg::SwipeXThrRst, tgc_pkg::SwipeYThrRst);
        1: program_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        2: program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        default: program_regs(16'($urandom), 16'($urandom_range(3000)),
                              16'($urandom_range(400)), 16'($urandom_range(400)));
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      poll_clock = $urandom;
      phase_polls = 0;
      // The sender stops halfway and lets every owed event come back
      // before it resumes.
      while (phase_polls < PhaseItems / 2) add_gesture();
      wait_drained();
      while (phase_polls < PhaseItems) add_gesture();
      wait_drained();
    end

    $display("Checked %0d gesture events from %0d polls over %0d register settings.",
             events_seen, polls_taken, settings_used);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches found.", error_count);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* touch_gesture_classifier.f */
src/tgc_pkg.sv
src/tgc_cfg.sv
src/tgc_classify.sv
src/touch_gesture_classifier.sv
dv/testbench.sv
